@@ rtl/core/fpis_pkg.sv @@
// ----------------------------------------------------------------------------
// fpis_pkg
// Shared codes and types of the front panel input scanner.
// ----------------------------------------------------------------------------
package fpis_pkg;

    localparam int KIND_W    = 2;
    localparam int UNIT_W    = 2;
    localparam int SETTING_W = 2;
    localparam int OUT_COUNT_W = 32;
    localparam int CFG_INDEX_W = 2;

    localparam logic [KIND_W-1:0] KIND_ROTATION = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRESS    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SWITCH   = 2'd2;

    localparam logic [SETTING_W-1:0] SET_UP      = 2'd0;
    localparam logic [SETTING_W-1:0] SET_MIDDLE  = 2'd1;
    localparam logic [SETTING_W-1:0] SET_DOWN    = 2'd2;
    localparam logic [SETTING_W-1:0] SET_UNKNOWN = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_ROTATION_ON = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_ON   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SWITCH_ON   = 2'd2;

    typedef struct packed {
        logic rotation_on;
        logic button_on;
        logic switch_on;
    } fpis_enables_t;

endpackage

@@ rtl/core/fpis_queue.sv @@
// ----------------------------------------------------------------------------
// fpis_queue
// Two-entry queue of event jobs between the front and back ends.
// ----------------------------------------------------------------------------
module fpis_queue
#(
    parameter int WIDTH = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_push,
    input  logic [WIDTH-1:0] q_push_data,
    output logic             q_full,
    input  logic             q_pop,
    output logic [WIDTH-1:0] q_pop_data,
    output logic             q_empty
);

    logic [1:0][WIDTH-1:0] mem_reg;
    logic                  wr_ptr_reg;
    logic                  wr_ptr_next;
    logic                  rd_ptr_reg;
    logic                  rd_ptr_next;
    logic [1:0]            fill_reg;
    logic [1:0]            fill_next;

    assign q_full     = fill_reg[1];
    assign q_empty    = (fill_reg == 2'd0);
    assign q_pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ q_push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        fill_next   = fill_reg + {1'b0, q_push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            mem_reg[wr_ptr_reg] <= q_push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

@@ rtl/core/fpis_front.sv @@
// ----------------------------------------------------------------------------
// fpis_front
// Takes snapshots, tracks encoder, button and switch state, builds event jobs.
// ----------------------------------------------------------------------------
module fpis_front
    import fpis_pkg::*;
#(
    parameter int NUM_ENCODERS = 3,
    parameter int NUM_SWITCHES = 3,
    parameter int COUNT_WIDTH  = 32,
    localparam int EV_W  = 2 * NUM_ENCODERS + NUM_SWITCHES,
    localparam int JOB_W = EV_W + NUM_ENCODERS * COUNT_WIDTH + NUM_ENCODERS
                           + SETTING_W * NUM_SWITCHES
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  fpis_enables_t           en,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [NUM_ENCODERS-1:0] quad_a_lines,
    input  logic [NUM_ENCODERS-1:0] quad_b_lines,
    input  logic [NUM_ENCODERS-1:0] push_lines,
    input  logic [NUM_SWITCHES-1:0] toggle_first_pins,
    input  logic [NUM_SWITCHES-1:0] toggle_second_pins,
    output logic                    q_push,
    output logic [JOB_W-1:0]        q_push_data,
    input  logic                    q_full
);

    logic                                     seeded_reg;
    logic [NUM_ENCODERS-1:0]                  prev_a_reg;
    logic [NUM_ENCODERS-1:0]                  held_reg;
    logic [NUM_SWITCHES-1:0]                  prev_first_reg;
    logic [NUM_SWITCHES-1:0]                  prev_second_reg;
    logic [NUM_ENCODERS-1:0][COUNT_WIDTH-1:0] count_reg;
    logic [NUM_ENCODERS-1:0][COUNT_WIDTH-1:0] count_next;
    logic [NUM_ENCODERS-1:0]                  step;
    logic [NUM_ENCODERS-1:0]                  cw;
    logic [NUM_SWITCHES-1:0][SETTING_W-1:0]   setting;
    logic [EV_W-1:0]                          mask;
    logic                                     accept;

    assign in_stall    = q_full;
    assign accept      = in_valid && !q_full;
    assign q_push      = accept && (mask != '0);
    assign q_push_data = {setting, cw, count_next, mask};

    always_comb
    begin
        mask = '0;
        for (int i = 0; i < NUM_ENCODERS; i++)
        begin
            step[i] = seeded_reg && (quad_a_lines[i] != prev_a_reg[i]);
            cw[i]   = (quad_a_lines[i] == quad_b_lines[i]);
            if (step[i])
            begin
                count_next[i] = cw[i] ? count_reg[i] + COUNT_WIDTH'(1)
                                      : count_reg[i] - COUNT_WIDTH'(1);
            end
            else
            begin
                count_next[i] = count_reg[i];
            end
            mask[2*i]     = step[i] && en.rotation_on;
            mask[2*i + 1] = !push_lines[i] && !held_reg[i] && en.button_on;
        end
        for (int j = 0; j < NUM_SWITCHES; j++)
        begin
            mask[2*NUM_ENCODERS + j] = seeded_reg && en.switch_on
                && ((toggle_first_pins[j] != prev_first_reg[j])
                    || (toggle_second_pins[j] != prev_second_reg[j]));
            unique case ({toggle_first_pins[j], toggle_second_pins[j]})
                2'b10:   setting[j] = SET_UP;
                2'b11:   setting[j] = SET_MIDDLE;
                2'b01:   setting[j] = SET_DOWN;
                default: setting[j] = SET_UNKNOWN;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg      <= 1'b0;
            prev_a_reg      <= '0;
            held_reg        <= '0;
            prev_first_reg  <= '0;
            prev_second_reg <= '0;
            count_reg       <= '0;
        end
        else if (accept)
        begin
            seeded_reg      <= 1'b1;
            prev_a_reg      <= quad_a_lines;
            held_reg        <= ~push_lines;
            prev_first_reg  <= toggle_first_pins;
            prev_second_reg <= toggle_second_pins;
            count_reg       <= count_next;
        end
    end

endmodule

@@ rtl/core/fpis_back.sv @@
// ----------------------------------------------------------------------------
// fpis_back
// Unpacks event jobs, emits one event per cycle unless stalled, lowest first.
// ----------------------------------------------------------------------------
module fpis_back
    import fpis_pkg::*;
#(
    parameter int NUM_ENCODERS = 3,
    parameter int NUM_SWITCHES = 3,
    parameter int COUNT_WIDTH  = 32,
    localparam int EV_W  = 2 * NUM_ENCODERS + NUM_SWITCHES,
    localparam int JOB_W = EV_W + NUM_ENCODERS * COUNT_WIDTH + NUM_ENCODERS
                           + SETTING_W * NUM_SWITCHES
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  logic [JOB_W-1:0]              q_pop_data,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [KIND_W-1:0]             event_kind,
    output logic [UNIT_W-1:0]             unit_index,
    output logic signed [OUT_COUNT_W-1:0] count_value,
    output logic                          turned_clockwise,
    output logic [SETTING_W-1:0]          toggle_setting,
    output logic                          last_event
);

    localparam int IDX_W = $clog2(EV_W);

    logic [EV_W-1:0]                          cur_mask_reg;
    logic [EV_W-1:0]                          cur_mask_next;
    logic [NUM_ENCODERS-1:0][COUNT_WIDTH-1:0] cur_count_reg;
    logic [NUM_ENCODERS-1:0]                  cur_cw_reg;
    logic [NUM_SWITCHES-1:0][SETTING_W-1:0]   cur_set_reg;

    logic [EV_W-1:0]                          job_mask;
    logic [NUM_ENCODERS-1:0][COUNT_WIDTH-1:0] job_count;
    logic [NUM_ENCODERS-1:0]                  job_cw;
    logic [NUM_SWITCHES-1:0][SETTING_W-1:0]   job_set;

    logic [EV_W-1:0]        rest;
    logic [IDX_W-1:0]       first_idx;
    logic                   found;
    logic [IDX_W-1:0]       unit_full;
    logic [KIND_W-1:0]      kind;
    logic [COUNT_WIDTH-1:0] sel_count;
    logic                   sel_cw;
    logic [SETTING_W-1:0]   sel_set;
    logic                   emit;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [KIND_W-1:0]             kind_reg;
    logic [UNIT_W-1:0]             unit_reg;
    logic signed [OUT_COUNT_W-1:0] count_out_reg;
    logic                          cw_out_reg;
    logic [SETTING_W-1:0]          set_out_reg;
    logic                          last_reg;

    assign {job_set, job_cw, job_count, job_mask} = q_pop_data;

    assign rest  = cur_mask_reg & (cur_mask_reg - EV_W'(1));
    assign emit  = (cur_mask_reg != '0) && (!out_valid_reg || !out_stall);
    assign q_pop = !q_empty && ((cur_mask_reg == '0) || (emit && (rest == '0)));

    always_comb
    begin
        first_idx = '0;
        found     = 1'b0;
        for (int k = 0; k < EV_W; k++)
        begin
            if (!found && cur_mask_reg[k])
            begin
                first_idx = IDX_W'(k);
                found     = 1'b1;
            end
        end

        if (first_idx < IDX_W'(2 * NUM_ENCODERS))
        begin
            kind      = first_idx[0] ? KIND_PRESS : KIND_ROTATION;
            unit_full = first_idx >> 1;
        end
        else
        begin
            kind      = KIND_SWITCH;
            unit_full = first_idx - IDX_W'(2 * NUM_ENCODERS);
        end

        sel_count = '0;
        sel_cw    = 1'b0;
        for (int e = 0; e < NUM_ENCODERS; e++)
        begin
            if (unit_full == IDX_W'(e))
            begin
                sel_count = cur_count_reg[e];
                sel_cw    = cur_cw_reg[e];
            end
        end
        sel_set = SET_UP;
        for (int s = 0; s < NUM_SWITCHES; s++)
        begin
            if (unit_full == IDX_W'(s))
            begin
                sel_set = cur_set_reg[s];
            end
        end
    end

    always_comb
    begin
        priority if (q_pop)
        begin
            cur_mask_next = job_mask;
        end
        else if (emit)
        begin
            cur_mask_next = rest;
        end
        else
        begin
            cur_mask_next = cur_mask_reg;
        end
        out_valid_next = emit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_count_reg <= job_count;
            cur_cw_reg    <= job_cw;
            cur_set_reg   <= job_set;
        end
        if (emit)
        begin
            kind_reg      <= kind;
            unit_reg      <= UNIT_W'(unit_full);
            count_out_reg <= (kind == KIND_ROTATION)
                             ? OUT_COUNT_W'($signed(sel_count)) : '0;
            cw_out_reg    <= (kind == KIND_ROTATION) && sel_cw;
            set_out_reg   <= (kind == KIND_SWITCH) ? sel_set : SET_UP;
            last_reg      <= (rest == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mask_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_mask_reg  <= cur_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign event_kind       = kind_reg;
    assign unit_index       = unit_reg;
    assign count_value      = count_out_reg;
    assign turned_clockwise = cw_out_reg;
    assign toggle_setting   = set_out_reg;
    assign last_event       = last_reg;

endmodule

@@ rtl/core/front_panel_input_scanner_unit.sv @@
// ----------------------------------------------------------------------------
// front_panel_input_scanner_unit
// Quadrature encoder, push button and three-position switch event scanner.
// ----------------------------------------------------------------------------
// A snapshot word is taken whenever the two-entry job queue has room, so
// snapshots may follow each other in consecutive cycles. The event emitter
// sends one event word per cycle while out_stall is low; a snapshot causes at
// most 2*NUM_ENCODERS+NUM_SWITCHES events (nine with the default sizes), and
// snapshots that cause no event are not queued and never reach the emitter.
// The first event of a snapshot passes the queue, job and output registers.
// ----------------------------------------------------------------------------
module front_panel_input_scanner_unit
    import fpis_pkg::*;
#(
    parameter int NUM_ENCODERS = 3,
    parameter int NUM_SWITCHES = 3,
    parameter int COUNT_WIDTH  = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic                          cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [NUM_ENCODERS-1:0]       quad_a_lines,
    input  logic [NUM_ENCODERS-1:0]       quad_b_lines,
    input  logic [NUM_ENCODERS-1:0]       push_lines,
    input  logic [NUM_SWITCHES-1:0]       toggle_first_pins,
    input  logic [NUM_SWITCHES-1:0]       toggle_second_pins,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [KIND_W-1:0]             event_kind,
    output logic [UNIT_W-1:0]             unit_index,
    output logic signed [OUT_COUNT_W-1:0] count_value,
    output logic                          turned_clockwise,
    output logic [SETTING_W-1:0]          toggle_setting,
    output logic                          last_event
);

    localparam int EV_W  = 2 * NUM_ENCODERS + NUM_SWITCHES;
    localparam int JOB_W = EV_W + NUM_ENCODERS * COUNT_WIDTH + NUM_ENCODERS
                           + SETTING_W * NUM_SWITCHES;

    fpis_enables_t    en_reg;
    fpis_enables_t    en_next;
    logic             q_push;
    logic [JOB_W-1:0] q_push_data;
    logic             q_full;
    logic             q_pop;
    logic [JOB_W-1:0] q_pop_data;
    logic             q_empty;

    always_comb
    begin
        en_next = en_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ROTATION_ON: en_next.rotation_on = cfg_data;
                REG_BUTTON_ON:   en_next.button_on   = cfg_data;
                REG_SWITCH_ON:   en_next.switch_on   = cfg_data;
                default:         en_next             = en_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= '0;
        end
        else
        begin
            en_reg <= en_next;
        end
    end

    fpis_front
    #(
        .NUM_ENCODERS (NUM_ENCODERS),
        .NUM_SWITCHES (NUM_SWITCHES),
        .COUNT_WIDTH  (COUNT_WIDTH)
    )
    u_front
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .en                 (en_reg),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .quad_a_lines       (quad_a_lines),
        .quad_b_lines       (quad_b_lines),
        .push_lines         (push_lines),
        .toggle_first_pins  (toggle_first_pins),
        .toggle_second_pins (toggle_second_pins),
        .q_push             (q_push),
        .q_push_data        (q_push_data),
        .q_full             (q_full)
    );

    fpis_queue
    #(
        .WIDTH (JOB_W)
    )
    u_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_push      (q_push),
        .q_push_data (q_push_data),
        .q_full      (q_full),
        .q_pop       (q_pop),
        .q_pop_data  (q_pop_data),
        .q_empty     (q_empty)
    );

    fpis_back
    #(
        .NUM_ENCODERS (NUM_ENCODERS),
        .NUM_SWITCHES (NUM_SWITCHES),
        .COUNT_WIDTH  (COUNT_WIDTH)
    )
    u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_pop_data       (q_pop_data),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .event_kind       (event_kind),
        .unit_index       (unit_index),
        .count_value      (count_value),
        .turned_clockwise (turned_clockwise),
        .toggle_setting   (toggle_setting),
        .last_event       (last_event)
    );

    a_kind_valid : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_kind == KIND_ROTATION || event_kind == KIND_PRESS
                       || event_kind == KIND_SWITCH))
        else $error("event word with undefined kind");

    a_rotation_only_fields : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind != KIND_ROTATION)
            |-> (count_value == '0 && !turned_clockwise))
        else $error("count or direction on a non-rotation event");

    a_switch_only_setting : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind != KIND_SWITCH) |-> (toggle_setting == SET_UP))
        else $error("switch setting on a non-switch event");

    a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("job pushed into a full queue");

endmodule
